/* src/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg
// shared constants, types and helpers for the servo slew pwm controller
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  localparam int CHANNELS = 7;

  localparam int CH_W     = 3;
  localparam int ANG_W    = 12;
  localparam int DUTY_W   = 16;
  localparam int LIM_W    = 56;
  localparam int STEP_W   = 12;
  localparam int PULSE_W  = 15;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 6;

  localparam logic [CH_W-1:0]  LAST_CH   = CH_W'(CHANNELS - 1);
  localparam logic [ANG_W-1:0] RESET_POS = ANG_W'(1440);

  // snap window, half a degree
  localparam logic signed [ANG_W:0] SNAP_LIMIT = (ANG_W+1)'(8);

  // register reset values
  localparam logic [LIM_W-1:0]   MIN_ANGLES_RST = '0;
  localparam logic [LIM_W-1:0]   MAX_ANGLES_RST = 56'hB4B4B4B4B4B4B4;
  localparam logic [STEP_W-1:0]  STEP_RST       = STEP_W'(48);
  localparam logic [PULSE_W-1:0] PMIN_RST       = PULSE_W'(500);
  localparam logic [PULSE_W-1:0] PMAX_RST       = PULSE_W'(2500);

  // register index (byte address / 8)
  localparam logic [2:0] REG_MIN_ANGLES = 3'd0;
  localparam logic [2:0] REG_MAX_ANGLES = 3'd1;
  localparam logic [2:0] REG_STEP_LIMIT = 3'd2;
  localparam logic [2:0] REG_PULSE_MIN  = 3'd3;
  localparam logic [2:0] REG_PULSE_MAX  = 3'd4;

  // duty = floor(num * 65535 / 57600000) = floor(num * 4369 / (2^11 * 1875))
  localparam int NUM_W      = 30;                    // signed numerator
  localparam int BASE_W     = 27;                    // pulse_min * 2880
  localparam logic [11:0] DEG_SCALE = 12'd2880;
  localparam logic [12:0] DUTY_MUL  = 13'd4369;
  localparam int DUTY_SHIFT = 11;
  localparam int Q_W        = 29;
  localparam int QS_W       = 27;                    // q below saturation
  localparam logic [Q_W-1:0] Q_SAT = Q_W'(122880000); // 65536 * 1875
  // ceil(2^38 / 1875): exact for q < 2^27
  localparam logic [27:0] RECIP       = 28'd146601551;
  localparam int          RECIP_SHIFT = 38;

  typedef struct packed {
    logic [LIM_W-1:0]   min_angles;
    logic [LIM_W-1:0]   max_angles;
    logic [STEP_W-1:0]  step_limit;
    logic [PULSE_W-1:0] pulse_min_us;
    logic [PULSE_W-1:0] pulse_max_us;
  } cfg_t;

  typedef struct packed {
    logic            wr_target;  // store a set-target word
    logic            step;       // slew update of channel idx
    logic            prod;       // numerator
    logic            scale;      // scale by 4369 / 2048
    logic            emit;       // reciprocal divide, load result
    logic [CH_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // channel limit in sixteenths of a degree
  function automatic logic [ANG_W-1:0] lim_of(input logic [LIM_W-1:0] angles,
                                              input logic [CH_W-1:0]  ch);
    logic [LIM_W-1:0] sh;
    sh = angles >> {ch, 3'b000};
    return {sh[7:0], 4'b0000};
  endfunction

  // lower limit wins first, then upper
  function automatic logic [ANG_W-1:0] clamp_lim(input logic [ANG_W-1:0] x,
                                                 input logic [ANG_W-1:0] lo,
                                                 input logic [ANG_W-1:0] hi);
    logic [ANG_W-1:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/ssp_if.sv */
// ----------------------------------------------------------------------------
// ssp_if
// request and result channels of the servo slew pwm controller
// ----------------------------------------------------------------------------
`default_nettype none

interface ssp_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [ssp_pkg::CH_W-1:0]    channel;
  logic [ssp_pkg::ANG_W-1:0]   target_angle;

  modport source (output valid, cmd, channel, target_angle, input ready);
  modport sink   (input valid, cmd, channel, target_angle, output ready);
endinterface

interface ssp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ssp_pkg::CH_W-1:0]    servo_index;
  logic [ssp_pkg::DUTY_W-1:0]  duty;
  logic                        last;

  modport source (output valid, servo_index, duty, last, input ready);
  modport sink   (input valid, servo_index, duty, last, output ready);
endinterface

`default_nettype wire

/* src/ssp_regs.sv */
// ----------------------------------------------------------------------------
// ssp_regs
// apb configuration registers
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ssp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ssp_pkg::DATA_W-1:0]   pwdata,
  output logic      [ssp_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output ssp_pkg::cfg_t                     cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ssp_pkg::ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_angles   <= ssp_pkg::MIN_ANGLES_RST;
      cfg.max_angles   <= ssp_pkg::MAX_ANGLES_RST;
      cfg.step_limit   <= ssp_pkg::STEP_RST;
      cfg.pulse_min_us <= ssp_pkg::PMIN_RST;
      cfg.pulse_max_us <= ssp_pkg::PMAX_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ssp_pkg::REG_MIN_ANGLES: cfg.min_angles   <= pwdata[ssp_pkg::LIM_W-1:0];
        ssp_pkg::REG_MAX_ANGLES: cfg.max_angles   <= pwdata[ssp_pkg::LIM_W-1:0];
        ssp_pkg::REG_STEP_LIMIT: cfg.step_limit   <= pwdata[ssp_pkg::STEP_W-1:0];
        ssp_pkg::REG_PULSE_MIN:  cfg.pulse_min_us <= pwdata[ssp_pkg::PULSE_W-1:0];
        ssp_pkg::REG_PULSE_MAX:  cfg.pulse_max_us <= pwdata[ssp_pkg::PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ssp_pkg::REG_MIN_ANGLES: prdata = ssp_pkg::DATA_W'(cfg.min_angles);
      ssp_pkg::REG_MAX_ANGLES: prdata = ssp_pkg::DATA_W'(cfg.max_angles);
      ssp_pkg::REG_STEP_LIMIT: prdata = ssp_pkg::DATA_W'(cfg.step_limit);
      ssp_pkg::REG_PULSE_MIN:  prdata = ssp_pkg::DATA_W'(cfg.pulse_min_us);
      ssp_pkg::REG_PULSE_MAX:  prdata = ssp_pkg::DATA_W'(cfg.pulse_max_us);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* src/ssp_ctrl.sv */
// ----------------------------------------------------------------------------
// ssp_ctrl
// sequencer: accepts words, walks channels on a tick
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic              req_cmd,
  output logic                   req_ready,
  input  wire ssp_pkg::dp_stat_t stat,
  output ssp_pkg::dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STEP  = 5'b00010,
    S_PROD  = 5'b00100,
    S_SCALE = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                   state, state_next;
  logic [ssp_pkg::CH_W-1:0] idx, idx_next;
  logic                     accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        if (accept && req_cmd) begin
          state_next = S_STEP;
          idx_next   = '0;
        end
      end
      S_STEP:  state_next = S_PROD;
      S_PROD:  state_next = S_SCALE;
      S_SCALE: state_next = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) begin
          if (idx == ssp_pkg::LAST_CH) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_STEP;
            idx_next   = idx + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.wr_target = accept && !req_cmd;
    cmd.step      = (state == S_STEP);
    cmd.prod      = (state == S_PROD);
    cmd.scale     = (state == S_SCALE);
    cmd.emit      = (state == S_EMIT) && stat.out_free;
    cmd.idx       = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

`default_nettype wire

/* src/ssp_dp.sv */
// ----------------------------------------------------------------------------
// ssp_dp
// position store, slew update and duty arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ssp_pkg::cfg_t                 cfg,
  input  wire ssp_pkg::dp_cmd_t              cmd,
  output ssp_pkg::dp_stat_t                  stat,
  input  wire logic [ssp_pkg::CH_W-1:0]      in_channel,
  input  wire logic [ssp_pkg::ANG_W-1:0]     in_angle,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [ssp_pkg::CH_W-1:0]      out_index,
  output logic      [ssp_pkg::DUTY_W-1:0]    out_duty,
  output logic                               out_last
);

  localparam int AW = ssp_pkg::ANG_W;

  logic [AW-1:0] target_pos  [ssp_pkg::CHANNELS];
  logic [AW-1:0] current_pos [ssp_pkg::CHANNELS];

  // set target
  logic [AW-1:0] tgt_clamped;
  logic          ch_ok;

  // slew
  logic [AW-1:0]        tgt, cur, new_cur, a_next;
  logic signed [AW:0]   diff, s_pos, s_neg, move;
  logic [AW:0]          sum;

  // arithmetic pipeline
  logic [AW-1:0]                       a;
  logic signed [ssp_pkg::PULSE_W:0]    span;
  logic signed [AW+ssp_pkg::PULSE_W:0] prod;
  logic [ssp_pkg::BASE_W-1:0]          base;
  logic signed [ssp_pkg::NUM_W-1:0]    num, num_next;
  logic [ssp_pkg::Q_W+12:0]            scaled;
  logic [ssp_pkg::Q_W-1:0]             q;
  logic                                neg;
  logic [ssp_pkg::QS_W+27:0]           recip_prod;
  logic [ssp_pkg::DUTY_W-1:0]          duty_next;

  assign stat.out_free = !out_valid || out_ready;

  assign ch_ok       = (int'(in_channel) < ssp_pkg::CHANNELS);
  assign tgt_clamped = ssp_pkg::clamp_lim(in_angle,
                                          ssp_pkg::lim_of(cfg.min_angles, in_channel),
                                          ssp_pkg::lim_of(cfg.max_angles, in_channel));

  // slew update: snap inside half a degree, else move by at most step_limit
  always_comb begin
    tgt   = target_pos[cmd.idx];
    cur   = current_pos[cmd.idx];
    diff  = $signed({1'b0, tgt}) - $signed({1'b0, cur});
    s_pos = $signed({1'b0, cfg.step_limit});
    s_neg = -s_pos;
    if (diff < s_neg) begin
      move = s_neg;
    end else if (diff > s_pos) begin
      move = s_pos;
    end else begin
      move = diff;
    end
    sum = {1'b0, cur} + move;
    if (diff < ssp_pkg::SNAP_LIMIT && diff > -ssp_pkg::SNAP_LIMIT) begin
      new_cur = tgt;
    end else begin
      new_cur = sum[AW-1:0];
    end
    a_next = ssp_pkg::clamp_lim(new_cur,
                                ssp_pkg::lim_of(cfg.min_angles, cmd.idx),
                                ssp_pkg::lim_of(cfg.max_angles, cmd.idx));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ssp_pkg::CHANNELS; i++) begin
        target_pos[i]  <= ssp_pkg::RESET_POS;
        current_pos[i] <= ssp_pkg::RESET_POS;
      end
    end else begin
      if (cmd.wr_target && ch_ok) begin
        target_pos[in_channel] <= tgt_clamped;
      end
      if (cmd.step) begin
        current_pos[cmd.idx] <= new_cur;
      end
    end
  end

  // numerator: pulse_min * 2880 + a * (pulse_max - pulse_min)
  always_comb begin
    span     = $signed({1'b0, cfg.pulse_max_us}) - $signed({1'b0, cfg.pulse_min_us});
    prod     = $signed({1'b0, a}) * span;
    base     = ssp_pkg::BASE_W'(cfg.pulse_min_us) * ssp_pkg::BASE_W'(ssp_pkg::DEG_SCALE);
    num_next = $signed({3'b000, base}) + ssp_pkg::NUM_W'(prod);
  end

  // scale by 4369 and drop 11 bits, then reciprocal of 1875
  always_comb begin
    scaled     = num[ssp_pkg::Q_W-1:0] * ssp_pkg::DUTY_MUL;
    recip_prod = q[ssp_pkg::QS_W-1:0] * ssp_pkg::RECIP;
    if (neg) begin
      duty_next = '0;
    end else if (q >= ssp_pkg::Q_SAT) begin
      duty_next = '1;
    end else begin
      duty_next = recip_prod[ssp_pkg::RECIP_SHIFT +: ssp_pkg::DUTY_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      a <= a_next;
    end
    if (cmd.prod) begin
      num <= num_next;
    end
    if (cmd.scale) begin
      q   <= scaled[ssp_pkg::DUTY_SHIFT +: ssp_pkg::Q_W];
      neg <= num[ssp_pkg::NUM_W-1];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index <= cmd.idx;
      out_duty  <= duty_next;
      out_last  <= (cmd.idx == ssp_pkg::LAST_CH);
    end
  end

endmodule

`default_nettype wire

/* src/servo_slew_pwm_controller.sv */
// ----------------------------------------------------------------------------
// servo_slew_pwm_controller
// slew-limited multi-channel servo position to pwm duty converter
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake       word contents
//  -------  ---  --------------  -----------------------------------------
//  req      in   valid / ready   cmd, channel, target_angle
//  rsp      out  valid / ready   servo_index, duty, last
//  apb      in   psel / penable  min/max angles, step limit, pulse widths
//
//  a set-target word is taken while idle and gives no result
//  a tick word walks the seven channels in order; each channel goes through
//  slew update, numerator multiply, scale multiply and reciprocal multiply
//  into the result register, and no new word is taken until the walk ends
//  the result register decouples the two sides; while it is full and not
//  taken the walk holds at the last multiply stage
//  reset (synchronous, active high) returns every channel to ninety degrees
//  and the configuration registers to their defaults
//
// ----------------------------------------------------------------------------
`default_nettype none

module servo_slew_pwm_controller (
  input  wire logic                         clk,
  input  wire logic                         rst,
  ssp_req_if.sink                           req,
  ssp_rsp_if.source                         rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ssp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ssp_pkg::DATA_W-1:0]   pwdata,
  output logic      [ssp_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  ssp_pkg::cfg_t     cfg;
  ssp_pkg::dp_cmd_t  dp_cmd;
  ssp_pkg::dp_stat_t dp_stat;

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  ssp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer owns the request handshake and the channel counter
  ssp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // positions, slew and duty arithmetic, result register
  ssp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .in_channel (req.channel),
    .in_angle   (req.target_angle),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_index  (rsp.servo_index),
    .out_duty   (rsp.duty),
    .out_last   (rsp.last)
  );

endmodule

`default_nettype wire

/* bench/ssp_tb_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_tb_pkg
// command and register codes shared by the servo controller bench files
// ----------------------------------------------------------------------------
package ssp_tb_pkg;

  localparam logic CMD_SET_TARGET = 1'b0;
  localparam logic CMD_TICK       = 1'b1;

  // address slot above the last mapped register
  localparam logic [2:0] REG_SPARE = 3'd5;

endpackage

/* bench/ssp_duty_check.sv */
// ----------------------------------------------------------------------------
// ssp_duty_check
// watches the request, result and register ports of the servo controller,
// keeps its own copy of targets, positions and limits, and compares every
// duty word against the value worked out for it
// ----------------------------------------------------------------------------
module ssp_duty_check
  import ssp_pkg::*;
  import ssp_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  ssp_req_if                req,
  ssp_rsp_if                rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatches,
  output int                duties_due
);

  localparam int     SNAP_WINDOW = 8;
  localparam longint DEG_TICKS   = 2880;
  localparam longint FULL_SCALE  = 65535;
  localparam longint FRAME_DIV   = 57600000;

  typedef struct {
    logic [CH_W-1:0]   idx;
    logic [DUTY_W-1:0] duty;
    logic              last;
  } duty_word_t;

  duty_word_t       duty_words_due[$];
  cfg_t             regs;
  logic [ANG_W-1:0] aim[CHANNELS];
  logic [ANG_W-1:0] pos[CHANNELS];
  int               errs;

  function automatic logic [ANG_W-1:0] floor_of(input int ch);
    return {regs.min_angles[8*ch +: 8], 4'b0000};
  endfunction

  function automatic logic [ANG_W-1:0] ceil_of(input int ch);
    return {regs.max_angles[8*ch +: 8], 4'b0000};
  endfunction

  // lower bound is tested first, so it wins nothing when lo > hi except below lo
  function automatic logic [ANG_W-1:0] bound(input logic [ANG_W-1:0] x,
                                             input logic [ANG_W-1:0] lo,
                                             input logic [ANG_W-1:0] hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_for(input logic [ANG_W-1:0] a);
    longint base, slope, num, q;
    base  = regs.pulse_min_us;
    slope = longint'(regs.pulse_max_us) - base;
    num   = (base * DEG_TICKS + longint'(a) * slope) * FULL_SCALE;
    if (num < 0) return '0;
    q = num / FRAME_DIV;
    return (q > FULL_SCALE) ? '1 : DUTY_W'(q);
  endfunction

  task automatic advance_servos();
    int         tgt, cur, diff, mag, lim;
    duty_word_t w;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      tgt  = aim[ch];
      cur  = pos[ch];
      diff = tgt - cur;
      lim  = regs.step_limit;
      mag  = (diff < 0) ? -diff : diff;
      if (mag < SNAP_WINDOW) begin
        cur = tgt;
      end else if (diff > lim) begin
        cur = cur + lim;
      end else if (diff < -lim) begin
        cur = cur - lim;
      end else begin
        cur = tgt;
      end
      pos[ch] = ANG_W'(cur);
      w.idx   = CH_W'(ch);
      w.duty  = duty_for(bound(pos[ch], floor_of(ch), ceil_of(ch)));
      w.last  = (ch == CHANNELS - 1);
      duty_words_due.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    duty_word_t want;
    if (rst) begin
      regs.min_angles   = MIN_ANGLES_RST;
      regs.max_angles   = MAX_ANGLES_RST;
      regs.step_limit   = STEP_RST;
      regs.pulse_min_us = PMIN_RST;
      regs.pulse_max_us = PMAX_RST;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        aim[ch] = RESET_POS;
        pos[ch] = RESET_POS;
      end
      duty_words_due.delete();
      errs = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:3])
          REG_MIN_ANGLES: regs.min_angles   = pwdata[LIM_W-1:0];
          REG_MAX_ANGLES: regs.max_angles   = pwdata[LIM_W-1:0];
          REG_STEP_LIMIT: regs.step_limit   = pwdata[STEP_W-1:0];
          REG_PULSE_MIN:  regs.pulse_min_us = pwdata[PULSE_W-1:0];
          REG_PULSE_MAX:  regs.pulse_max_us = pwdata[PULSE_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (duty_words_due.size() == 0) begin
          $error("duty word for servo %0d arrived with nothing expected", rsp.servo_index);
          errs++;
        end else begin
          want = duty_words_due.pop_front();
          if (rsp.servo_index !== want.idx) begin
            $error("servo_index mismatch: expected %0d, got %0d", want.idx, rsp.servo_index);
            errs++;
          end
          if (rsp.duty !== want.duty) begin
            $error("duty mismatch: expected %0d, got %0d", want.duty, rsp.duty);
            errs++;
          end
          if (rsp.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, rsp.last);
            errs++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.cmd == CMD_TICK) begin
          advance_servos();
        end else if (req.channel < CHANNELS) begin
          aim[req.channel] = bound(req.target_angle, floor_of(req.channel),
                                   ceil_of(req.channel));
        end
      end
    end
    mismatches <= errs;
    duties_due <= duty_words_due.size();
  end

endmodule

/* bench/tb_servo_slew_pwm_controller.sv */
// ----------------------------------------------------------------------------
// tb_servo_slew_pwm_controller
// drives set-target and tick words and register writes into the servo
// controller under random idling on both sides, and reports the verdict
// from the duty checker that runs beside it
// ----------------------------------------------------------------------------
module tb_servo_slew_pwm_controller;
  import ssp_pkg::*;
  import ssp_tb_pkg::*;

  // quiet cycles before a register write, covers the walk of a whole tick
  localparam int SETTLE_CYCLES = 40;
  // long result-side hold-off so the block backs up into its input
  localparam int HOLD_CYCLES   = 400;
  // cycles with no accepted word of any kind before giving up
  localparam int STALL_LIMIT   = 3000;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int duties_due;
  int idle_cycles = 0;
  int tx_quiet    = 0;
  int rx_quiet    = 0;
  bit calm        = 1'b0;   // no idling at all in the closing stretch
  bit hold_req    = 1'b0;   // asks the result side for one long hold-off

  ssp_req_if req_ch ();
  ssp_rsp_if rsp_ch ();

  servo_slew_pwm_controller dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ssp_duty_check duty_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .duties_due (duties_due)
  );

  always #6 clk = ~clk;

  // result side: short random stalls, quiet stretches, and the long hold
  // when asked for; the hold is counted here so the sender keeps offering
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (!calm && rx_quiet == 0 && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (rx_quiet > 0) begin
          rx_quiet--;
        end else if ($urandom_range(0, 39) == 0) begin
          rx_quiet = $urandom_range(20, 100);
        end
      end
    end
  end

  // watchdog: any accepted word, result or register access restarts it
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request word; an optional gap with valid low goes in front of it,
  // valid stays high across back-to-back words
  task automatic send_word(input logic c, input logic [CH_W-1:0] ch,
                           input logic [ANG_W-1:0] ang);
    int gap;
    gap = 0;
    if (!calm) begin
      if (tx_quiet > 0) begin
        tx_quiet--;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 14);
      end else if ($urandom_range(0, 19) == 0) begin
        tx_quiet = $urandom_range(10, 30);
      end
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= c;
    req_ch.channel      <= ch;
    req_ch.target_angle <= ang;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // tick with random junk in the fields it ignores
  task automatic send_tick();
    send_word(CMD_TICK, CH_W'($urandom_range(0, 7)), ANG_W'($urandom));
  endtask

  // stop offering and wait for every duty word still owed
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (duties_due != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only once the block has gone idle
  task automatic load_config(input logic [LIM_W-1:0] lo, input logic [LIM_W-1:0] hi,
                             input logic [STEP_W-1:0] step,
                             input logic [PULSE_W-1:0] pmin,
                             input logic [PULSE_W-1:0] pmax);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_MIN_ANGLES, DATA_W'(lo));
    write_reg(REG_MAX_ANGLES, DATA_W'(hi));
    write_reg(REG_STEP_LIMIT, DATA_W'(step));
    write_reg(REG_PULSE_MIN, DATA_W'(pmin));
    write_reg(REG_PULSE_MAX, DATA_W'(pmax));
  endtask

  // mostly servo-like settings, now and then raw register noise
  task automatic load_random_config();
    logic [LIM_W-1:0]   lo, hi;
    logic [STEP_W-1:0]  step;
    logic [PULSE_W-1:0] pmin, pmax;
    if ($urandom_range(0, 4) == 0) begin
      lo = LIM_W'({$urandom, $urandom});
      hi = LIM_W'({$urandom, $urandom});
    end else begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        lo[8*ch +: 8] = 8'($urandom_range(0, 90));
        hi[8*ch +: 8] = 8'($urandom_range(90, 255));
      end
    end
    case ($urandom_range(0, 5))
      0:       step = '0;
      1:       step = '1;
      2:       step = STEP_W'($urandom_range(1, 16));
      default: step = STEP_W'($urandom_range(1, 2880));
    endcase
    if ($urandom_range(0, 4) == 0) begin
      pmin = PULSE_W'($urandom);
      pmax = PULSE_W'($urandom);
    end else begin
      pmin = PULSE_W'($urandom_range(400, 1000));
      pmax = PULSE_W'($urandom_range(1800, 2600));
    end
    load_config(lo, hi, step, pmin, pmax);
  endtask

  // random stretch: mostly target updates then ticks so positions slew and
  // settle; some targets sit close to mid travel to hit the snap window
  task automatic run_random(input int count, input bit with_hold, input bit with_pause);
    logic [CH_W-1:0]  ch;
    logic [ANG_W-1:0] ang;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 2) begin
        // result side freezes while ticks keep coming; input must back up
        hold_req = 1'b1;
        repeat (4) send_tick();
      end
      if (with_pause && i == count / 4) begin
        drain();
      end
      if ($urandom_range(0, 99) < 30) begin
        send_tick();
      end else begin
        ch = ($urandom_range(0, 15) == 0) ? CH_W'(7) : CH_W'($urandom_range(0, CHANNELS - 1));
        case ($urandom_range(0, 3))
          0:       ang = ANG_W'($urandom_range(1430, 1450));
          1:       ang = ($urandom_range(0, 1) == 0) ? '0 : '1;
          default: ang = ANG_W'($urandom);
        endcase
        send_word(CMD_SET_TARGET, ch, ang);
      end
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.cmd          <= CMD_SET_TARGET;
    req_ch.channel      <= '0;
    req_ch.target_angle <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: every channel at ninety degrees
    send_tick();
    send_word(CMD_SET_TARGET, 3'd0, 12'd0);       // lower travel end
    send_word(CMD_SET_TARGET, 3'd1, 12'hFFF);     // above the upper limit
    send_word(CMD_SET_TARGET, 3'd2, 12'd1445);    // inside the snap window
    send_word(CMD_SET_TARGET, 3'd3, 12'd1433);    // also inside it, below
    send_word(CMD_SET_TARGET, 3'd4, 12'd2000);
    send_word(CMD_SET_TARGET, 3'd5, 12'd1488);    // exactly one step away
    send_word(CMD_SET_TARGET, 3'd6, 12'd1489);
    send_word(CMD_SET_TARGET, 3'd7, 12'h555);     // channel that does not exist
    send_tick();
    send_tick();

    // wide open limits, largest step, rising slope up to the top pulse width
    load_config('0, '1, '1, '0, '1);
    write_reg(REG_SPARE, '1);                     // unmapped slot, must change nothing
    send_word(CMD_SET_TARGET, 3'd0, 12'hFFF);
    send_word(CMD_SET_TARGET, 3'd6, 12'd0);
    send_tick();

    // lower limit above upper, zero step (snap only), falling slope
    load_config('1, '0, '0, '1, '0);
    send_word(CMD_SET_TARGET, 3'd0, 12'd0);
    send_word(CMD_SET_TARGET, 3'd1, 12'hFFF);
    send_word(CMD_SET_TARGET, 3'd2, 12'd4080);
    send_tick();
    send_tick();

    // both pulse widths at the top: duty saturates high
    load_config(LIM_W'({$urandom, $urandom}), LIM_W'({$urandom, $urandom}),
                STEP_W'(2880), '1, '1);
    send_word(CMD_SET_TARGET, 3'd3, 12'h800);
    send_tick();

    // random part, settings changed between stretches
    load_random_config();
    run_random(50, 1'b0, 1'b1);
    load_random_config();
    run_random(50, 1'b1, 1'b0);
    for (int p = 0; p < 3; p++) begin
      load_random_config();
      run_random(50, 1'b0, 1'b0);
    end
    load_config(MIN_ANGLES_RST, MAX_ANGLES_RST, STEP_RST, PMIN_RST, PMAX_RST);
    calm = 1'b1;
    run_random(50, 1'b0, 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && duties_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
